// ===== hdl/sud_pkg.sv =====
// Package: shared constants and the queue word type of the sort-and-deduplicate block.
package sud_pkg;

	// Default capacity of the element chain.
	localparam int DEPTH_DEF = 32;

	// Decoupling queue between front and back; the depth must be a power of two.
	localparam int FQ_DEPTH = 4;
	localparam int FQ_AW    = $clog2(FQ_DEPTH);
	localparam int FQ_CW    = $clog2(FQ_DEPTH + 1);

	localparam int VAL_W = 32;

	// One classified element on its way from front to back.
	typedef struct packed {
		logic signed [VAL_W-1:0] value;
		logic                    drop;      // raw count reached DEPTH, do not insert
		logic                    last_item; // closes the set, start the emit
		logic                    overflow;  // set-wide overflow, valid with last_item
	} entry_t;

endpackage

// ===== hdl/sud_in_if.sv =====
// Interface: input channel carrying one element word per handshake.
interface sud_in_if;
	logic        valid;
	logic        ready;
	logic signed [31:0] value;
	logic        last_item;

	modport source (output valid, output value, output last_item, input ready);
	modport sink (input valid, input value, input last_item, output ready);
endinterface

// ===== hdl/sud_out_if.sv =====
// Interface: output channel carrying one distinct result word per handshake.
interface sud_out_if;
	logic        valid;
	logic        ready;
	logic signed [31:0] unique_value;
	logic        last_result;
	logic        overflow;

	modport source (output valid, output unique_value, output last_result, output overflow,
		input ready);
	modport sink (input valid, input unique_value, input last_result, input overflow,
		output ready);
endinterface

// ===== hdl/sud_front.sv =====
// Module: front end that accepts element words, counts the set and flags overflow.
module sud_front #(
	parameter int DEPTH = sud_pkg::DEPTH_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	sud_in_if.sink          items,
	output logic            push_valid,
	input  logic            push_ready,
	output sud_pkg::entry_t push_entry
);
	import sud_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);

	logic [CW-1:0] count_q;
	logic          ovf_q;
	logic          full;
	logic          acc;

	assign full         = (count_q == CW'(DEPTH));
	assign items.ready  = push_ready;
	assign push_valid   = items.valid;
	assign acc          = items.valid && push_ready;

	always_comb begin
		push_entry.value     = items.value;
		push_entry.drop      = full;
		push_entry.last_item = items.last_item;
		push_entry.overflow  = ovf_q || full;
	end

	// Count raw elements; drop once DEPTH raw elements are counted.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ovf_q   <= 1'b0;
		end else if (acc) begin
			if (items.last_item) begin
				count_q <= '0;
				ovf_q   <= 1'b0;
			end else begin
				if (!full)
					count_q <= count_q + 1'b1;
				ovf_q <= ovf_q || full;
			end
		end
	end

endmodule

// ===== hdl/sud_fifo.sv =====
// Module: short queue that decouples the front end from the insertion chain.
module sud_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push_valid,
	output logic            push_ready,
	input  sud_pkg::entry_t push_entry,
	output logic            pop_valid,
	input  logic            pop_ready,
	output sud_pkg::entry_t pop_entry
);
	import sud_pkg::*;

	entry_t           mem_q [FQ_DEPTH];
	logic [FQ_AW-1:0] wr_ptr_q;
	logic [FQ_AW-1:0] rd_ptr_q;
	logic [FQ_CW-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (count_q != FQ_CW'(FQ_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_entry  = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= push_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== hdl/sud_back.sv =====
// Module: sorted insertion chain with duplicate suppression and result emitter.
module sud_back #(
	parameter int DEPTH = sud_pkg::DEPTH_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            pop_valid,
	output logic            pop_ready,
	input  sud_pkg::entry_t pop_entry,
	sud_out_if.source       results
);
	import sud_pkg::*;

	logic signed [VAL_W-1:0] data_q  [DEPTH];
	logic        [DEPTH-1:0] valid_q;
	logic                    emitting_q;
	logic                    ovf_q;

	logic                    out_valid_q;
	logic signed [VAL_W-1:0] out_value_q;
	logic                    out_last_q;
	logic                    out_ovf_q;

	logic [DEPTH-1:0]        sh;
	logic [DEPTH-1:0]        eq;
	logic [DEPTH-1:0]        lead;
	logic [DEPTH-1:0]        prev_v;
	logic [DEPTH-1:0]        next_v;
	logic signed [VAL_W-1:0] prev_d [DEPTH];
	logic signed [VAL_W-1:0] next_d [DEPTH];
	logic                    dup;
	logic                    pop;
	logic                    ins;
	logic                    emit_go;
	logic                    emit_end;

	assign pop_ready = !emitting_q;
	assign pop       = pop_valid && !emitting_q;

	// Per cell: does the new value go here or before, and is it already held.
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			sh[i] = !valid_q[i] || (data_q[i] > pop_entry.value);
			eq[i] = valid_q[i] && (data_q[i] == pop_entry.value);
		end
	end

	// Neighbor wiring of the chain.
	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		if (g == 0) begin : g_head
			assign lead[g]   = sh[g];
			assign prev_v[g] = 1'b1;
			assign prev_d[g] = pop_entry.value;
		end else begin : g_body
			assign lead[g]   = sh[g] && !sh[g-1];
			assign prev_v[g] = valid_q[g-1];
			assign prev_d[g] = data_q[g-1];
		end
		if (g == DEPTH - 1) begin : g_tail
			assign next_v[g] = 1'b0;
			assign next_d[g] = data_q[g];
		end else begin : g_inner
			assign next_v[g] = valid_q[g+1];
			assign next_d[g] = data_q[g+1];
		end
	end

	assign dup      = |eq;
	assign ins      = pop && !pop_entry.drop && !dup;
	assign emit_go  = emitting_q && (!out_valid_q || results.ready);
	assign emit_end = emit_go && !valid_q[1];

	// Insert by shifting the greater cells up; emit by shifting the chain down.
	always_ff @(posedge clk) begin
		for (int i = 0; i < DEPTH; i++) begin
			if (ins && sh[i])
				data_q[i] <= lead[i] ? pop_entry.value : prev_d[i];
			else if (emit_go)
				data_q[i] <= next_d[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			emitting_q <= 1'b0;
			ovf_q      <= 1'b0;
		end else begin
			for (int i = 0; i < DEPTH; i++) begin
				if (ins && sh[i])
					valid_q[i] <= lead[i] ? 1'b1 : prev_v[i];
				else if (emit_go)
					valid_q[i] <= next_v[i];
			end
			if (pop && pop_entry.last_item) begin
				emitting_q <= 1'b1;
				ovf_q      <= pop_entry.overflow;
			end else if (emit_end) begin
				emitting_q <= 1'b0;
			end
		end
	end

	// Output register: hold the word until it is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_go) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_go) begin
			out_value_q <= data_q[0];
			out_last_q  <= !valid_q[1];
			out_ovf_q   <= ovf_q;
		end
	end

	assign results.valid        = out_valid_q;
	assign results.unique_value = out_value_q;
	assign results.last_result  = out_last_q;
	assign results.overflow     = out_ovf_q;

	for (genvar g = 1; g < DEPTH; g++) begin : g_prefix_chk
		a_valid_prefix: assert property (@(posedge clk) disable iff (!arst_n)
			valid_q[g] |-> valid_q[g-1])
			else $error("chain valid bits not contiguous");
	end

	a_no_full_insert: assert property (@(posedge clk) disable iff (!arst_n)
		ins |-> !valid_q[DEPTH-1])
		else $error("insert into a full chain");

	a_emit_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		emitting_q |-> valid_q[0])
		else $error("emitting from an empty chain");

	a_emit_drains: assert property (@(posedge clk) disable iff (!arst_n)
		emit_end |=> !emitting_q && !valid_q[0])
		else $error("chain not empty after final result");

endmodule

// ===== hdl/sort_and_deduplicate.sv =====
// Top level: sorts a set of Q16.16 values and emits the distinct ones in ascending order.
// Throughput: one element word per cycle while loading and the queue has room; one result
//   word per cycle during the emit while results.ready holds, set by the single chain shift.
// Path: with the queue empty, the marked word passes the queue register, the chain insert that
//   starts the emit and the output register before the first result is valid.
// Loading of the next set continues during an emit until the 4-word queue fills.
// Reset (arst_n low): counters, queue pointers, chain valid bits and output valid clear.
module sort_and_deduplicate #(
	parameter int DEPTH = sud_pkg::DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	sud_in_if.sink    items,
	sud_out_if.source results
);
	import sud_pkg::*;

	// Front to queue.
	logic   push_valid;
	logic   push_ready;
	entry_t push_entry;

	// Queue to back.
	logic   pop_valid;
	logic   pop_ready;
	entry_t pop_entry;

	// Front: count raw elements of the set, mark drops once DEPTH are counted,
	// and stamp the set-wide overflow onto the marked word.
	sud_front #(
		.DEPTH (DEPTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.items      (items),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_entry (push_entry)
	);

	// Queue: lets loading run on while the back end drains the previous set.
	sud_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_entry (push_entry),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_entry  (pop_entry)
	);

	// Back: keep distinct values sorted in a chain of cells, one insert per cycle while no emit runs;
	// after the marked word, shift them out lowest first.
	sud_back #(
		.DEPTH (DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_entry (pop_entry),
		.results   (results)
	);

endmodule
